// ----- hdl/lcg_value_noise_1d_core_assert.svh -----
// Assertion macros used by the value noise checker.
`ifndef LCG_VALUE_NOISE_1D_CORE_ASSERT_SVH
`define LCG_VALUE_NOISE_1D_CORE_ASSERT_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define LVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define LVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lvn_pkg.sv -----
// Constants, types, cosine table and microcode for the value noise core.
package lvn_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned CosDepth    = 256;
  localparam int unsigned MaxWave     = 1024;
  localparam int unsigned SampleW     = 32;
  localparam int unsigned AmpW        = 16;
  localparam int unsigned AmpFracBits = 8;
  localparam int unsigned WaveW       = 11;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;

  localparam int unsigned PhaseW  = $clog2(MaxWave);
  localparam int unsigned TabIdxW = $clog2(CosDepth);
  localparam int unsigned TabW    = FracBits + 1;
  localparam int unsigned QuotW   = TabIdxW + 2;
  localparam int unsigned NumW    = PhaseW + QuotW + 1;
  localparam int unsigned DivW    = WaveW + 1;
  localparam int unsigned CntW    = $clog2(QuotW);
  localparam int unsigned MagW    = FracBits + 1;
  localparam int unsigned FracW   = FracBits + 1;
  localparam int unsigned MulAW   = SampleW + 1;
  localparam int unsigned MulBW   = 22;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned SumW    = SampleW + 2;

  localparam logic [SampleW-1:0] LcgMul = 32'd1664525;
  localparam logic [SampleW-1:0] LcgAdd = 32'd1;

  // floor(x/5) == (x * DivFiveMul) >> DivFiveShift for every x below 2**18
  localparam logic [MulBW-1:0] DivFiveMul   = 22'd52429;
  localparam int unsigned      DivFiveShift = 18;

  localparam logic signed [AmpW-1:0] AmpReset  = 16'sd256;
  localparam logic [WaveW-1:0]       WaveReset = 11'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED       = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_WAVELENGTH = 2'd2
  } cfg_idx_e;

  // ---------------------------------------------------------------------------
  // Quarter-wave cosine table, Q1.FracBits, built at elaboration from a
  // Q2.30 Taylor series with terms up to x**16.
  // ---------------------------------------------------------------------------
  localparam longint unsigned PiQ30    = 64'd3373259426;
  localparam longint unsigned TwoDepth = 64'(2 * CosDepth);
  localparam longint          RoundQ30 = longint'(1) <<< (29 - FracBits);
  localparam longint          OneQf    = longint'(1) <<< FracBits;
  localparam longint unsigned TaylorDiv [8] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };

  typedef logic [TabW-1:0] cos_tab_t [CosDepth];

  function automatic cos_tab_t build_cos_table();
    cos_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint          sum;
    longint          v;
    int              i;
    int              k;
    for (i = 0; i < CosDepth; i++) begin
      x   = (PiQ30 * 64'(i)) / TwoDepth;
      x2  = (x * x) >> 30;
      mag = 64'd1 << 30;
      sum = longint'(mag);
      for (k = 0; k < 8; k++) begin
        mag = ((mag * x2) >> 30) / TaylorDiv[k];
        if (k[0] == 1'b0) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      v = (sum + RoundQ30) >>> (30 - FracBits);
      if (v < 0) begin
        v = 0;
      end
      if (v > OneQf) begin
        v = OneQf;
      end
      tab[i] = TabW'(v);
    end
    return tab;
  endfunction

  localparam cos_tab_t CosTable = build_cos_table();

  // ---------------------------------------------------------------------------
  // Microcode
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    MA_LCG  = 2'd0,
    MA_DIFF = 2'd1,
    MA_MAG  = 2'd2,
    MA_Y    = 2'd3
  } mula_sel_e;

  typedef enum logic [1:0] {
    MB_LCG  = 2'd0,
    MB_FIVE = 2'd1,
    MB_FRAC = 2'd2,
    MB_AMP  = 2'd3
  } mulb_sel_e;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_DISPATCH  = 4'd1,
    OP_DIV_STEP  = 4'd2,
    OP_FRAC      = 4'd3,
    OP_BLEND     = 4'd4,
    OP_LCG       = 4'd5,
    OP_KNOT      = 4'd6,
    OP_FROM_DRAW = 4'd7,
    OP_TO_DRAW   = 4'd8,
    OP_OUT       = 4'd9
  } dp_op_e;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_WAIT_IN  = 3'd2,
    J_IF_KNOT  = 3'd3,
    J_LOOP     = 3'd4,
    J_WAIT_OUT = 3'd5
  } jump_e;

  localparam int unsigned UpcW = 4;
  typedef logic [UpcW-1:0] upc_t;

  typedef struct packed {
    mula_sel_e mul_a;
    mulb_sel_e mul_b;
    logic      mul_en;
    dp_op_e    op;
    jump_e     jmp;
    upc_t      target;
  } uword_t;

  localparam upc_t UpcIdle  = upc_t'(0);
  localparam upc_t UpcDisp  = upc_t'(1);
  localparam upc_t UpcDiv   = upc_t'(2);
  localparam upc_t UpcLook  = upc_t'(3);
  localparam upc_t UpcBmul  = upc_t'(4);
  localparam upc_t UpcBlend = upc_t'(5);
  localparam upc_t UpcGmul  = upc_t'(6);
  localparam upc_t UpcOut   = upc_t'(7);
  localparam upc_t UpcK1    = upc_t'(8);
  localparam upc_t UpcK2    = upc_t'(9);
  localparam upc_t UpcK3    = upc_t'(10);
  localparam upc_t UpcP0    = upc_t'(11);
  localparam upc_t UpcP1    = upc_t'(12);
  localparam upc_t UpcP2    = upc_t'(13);
  localparam upc_t UpcP3    = upc_t'(14);
  localparam upc_t UpcP4    = upc_t'(15);

  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    w = '{mul_a: MA_LCG, mul_b: MB_LCG, mul_en: 1'b0, op: OP_NONE,
          jmp: J_NEXT, target: UpcIdle};
    case (upc)
      UpcIdle: begin
        w.jmp = J_WAIT_IN;
      end
      UpcDisp: begin
        w.mul_en = 1'b1;
        w.op     = OP_DISPATCH;
        w.jmp    = J_IF_KNOT;
        w.target = UpcK1;
      end
      UpcDiv: begin
        w.op  = OP_DIV_STEP;
        w.jmp = J_LOOP;
      end
      UpcLook: begin
        w.op = OP_FRAC;
      end
      UpcBmul: begin
        w.mul_a  = MA_DIFF;
        w.mul_b  = MB_FRAC;
        w.mul_en = 1'b1;
      end
      UpcBlend: begin
        w.op = OP_BLEND;
      end
      UpcGmul: begin
        w.mul_a  = MA_Y;
        w.mul_b  = MB_AMP;
        w.mul_en = 1'b1;
      end
      UpcOut: begin
        w.op     = OP_OUT;
        w.jmp    = J_WAIT_OUT;
        w.target = UpcIdle;
      end
      UpcK1: begin
        w.op = OP_LCG;
      end
      UpcK2: begin
        w.mul_a  = MA_MAG;
        w.mul_b  = MB_FIVE;
        w.mul_en = 1'b1;
      end
      UpcK3: begin
        w.op     = OP_KNOT;
        w.jmp    = J_GOTO;
        w.target = UpcGmul;
      end
      UpcP0: begin
        w.mul_en = 1'b1;
      end
      UpcP1: begin
        w.op = OP_LCG;
      end
      UpcP2: begin
        w.mul_en = 1'b1;
        w.op     = OP_FROM_DRAW;
      end
      UpcP3: begin
        w.op = OP_LCG;
      end
      UpcP4: begin
        w.op     = OP_TO_DRAW;
        w.jmp    = J_GOTO;
        w.target = UpcIdle;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = UpcIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/lcg_value_noise_1d_core.sv -----
// One-dimensional value noise source with cosine easing, microcoded datapath.
//
// Input channel (in_valid_i / in_stall_o / tick_i): each accepted item with
// tick_i = 1 produces exactly one result; an item with tick_i = 0 is taken
// and dropped without touching any state.
// Output channel (out_valid_o / out_stall_i / sample_o / at_knot_o): one
// output register; a stalled result holds its value until taken, and the
// next item is already accepted and worked on meanwhile.
// Config port (cfg_we_i / cfg_idx_i / cfg_data_i): seed, amplitude,
// wavelength. A seed write reloads the generator and draws the two first
// knots, with the input stalled.
// Work: an item that lands on a knot skips the division; an item between
// knots runs the 10-step restoring divider that maps phase onto the cosine
// table. A new item is accepted only once the sequencer is back at idle;
// one shared multiplier serves the generator, knot step, blend and gain.
// Reset: amplitude 1.0, wavelength 10, seed 0; the block then primes its
// knots before it accepts the first item. If the receiver stalls, a
// finished result waits at the last step until the output is free.
module lcg_value_noise_1d_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                tick_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lvn_pkg::SampleW-1:0]  sample_o,
  output logic                                at_knot_o,
  input  logic                                cfg_we_i,
  input  logic        [lvn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [lvn_pkg::CfgDataW-1:0] cfg_data_i
);
  import lvn_pkg::*;

  // Saturate a wide signed value to the sample range.
  function automatic logic signed [SampleW-1:0] sat_sample(
    input logic signed [ProdW-1:0] v
  );
    logic [ProdW-SampleW:0] top;
    top = v[ProdW-1:SampleW-1];
    if ((&top) || !(|top)) begin
      return v[SampleW-1:0];
    end
    return v[ProdW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
  endfunction

  // Sequencer
  upc_t   pc_q, pc_d, pc_inc;
  uword_t uw;
  logic   start;
  logic   out_block;
  logic   out_load;
  logic   seed_wr;

  // Architectural state and configuration
  logic        [SampleW-1:0] lcg_q;
  logic signed [SampleW-1:0] from_q, to_q;
  logic        [PhaseW-1:0]  phase_q, phase_d;
  logic signed [AmpW-1:0]    amp_q;
  logic        [WaveW-1:0]   wave_q;

  // Working registers
  logic        [DivW-1:0]    rem_q;
  logic        [QuotW-1:0]   numlo_q;
  logic        [CntW-1:0]    cnt_q;
  logic        [FracW-1:0]   f_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [SampleW-1:0] y_q;
  logic                      knot_q;

  // Output register
  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      out_knot_q;

  // Datapath nets
  logic        [WaveW-1:0]    wl_eff;
  logic        [PhaseW-1:0]   p_eff;
  logic                       p_zero;
  logic        [WaveW-1:0]    p_nxt;
  logic        [NumW-1:0]     num;
  logic        [DivW-1:0]     divisor;
  logic        [DivW:0]       trial;
  logic                       q_bit;
  logic        [DivW-1:0]     rem_nxt;
  logic                       draw_neg;
  logic signed [FracBits-1:0] draw_r;
  logic        [MagW-1:0]     mag;
  logic        [MagW-1:0]     mag_p2;
  logic        [TabIdxW-1:0]  tab_idx;
  logic        [TabW-1:0]     tab_val;
  logic        [FracBits+1:0] f_sum;
  logic        [FracW-1:0]    f_d;
  logic signed [MulAW-1:0]    mul_a;
  logic signed [MulBW-1:0]    mul_b;
  logic        [SampleW-1:0]  lcg_nxt;
  logic        [FracBits-1:0] step_mag;
  logic signed [SumW-1:0]     step;
  logic signed [SumW-1:0]     knot_sum;
  logic signed [SampleW-1:0]  knot_nxt;
  logic signed [ProdW-1:0]    bl_rnd, bl_sh;
  logic signed [SampleW-1:0]  y_blend;
  logic signed [ProdW-1:0]    g_rnd, g_sh;
  logic signed [SampleW-1:0]  gain;

  assign seed_wr    = cfg_we_i && (cfg_idx_i == CFG_SEED);
  assign in_stall_o = (pc_q != UpcIdle) || cfg_we_i;
  assign start      = in_valid_i && !in_stall_o && tick_i;
  assign out_block  = out_valid_q && out_stall_i;

  // Fetch the control word and pick the next step.
  always_comb begin
    uw       = ucode(pc_q);
    pc_inc   = pc_q + upc_t'(1);
    out_load = (uw.op == OP_OUT) && !out_block;
    case (uw.jmp)
      J_NEXT:     pc_d = pc_inc;
      J_GOTO:     pc_d = uw.target;
      J_WAIT_IN:  pc_d = start ? pc_inc : pc_q;
      J_IF_KNOT:  pc_d = p_zero ? uw.target : pc_inc;
      J_LOOP:     pc_d = (cnt_q == '0) ? pc_inc : pc_q;
      J_WAIT_OUT: pc_d = out_block ? pc_q : uw.target;
      default:    pc_d = UpcIdle;
    endcase
    // A seed write restarts priming from wherever the sequencer is.
    if (seed_wr) begin
      pc_d = UpcP0;
    end
  end

  // Effective wavelength and phase; zero and oversize wavelengths are clamped,
  // and a phase left beyond a newly shortened wavelength counts as a knot.
  always_comb begin
    if (wave_q == '0) begin
      wl_eff = WaveW'(1);
    end else if (wave_q > WaveW'(MaxWave)) begin
      wl_eff = WaveW'(MaxWave);
    end else begin
      wl_eff = wave_q;
    end
    p_eff   = (WaveW'(phase_q) < wl_eff) ? phase_q : '0;
    p_zero  = (p_eff == '0);
    p_nxt   = WaveW'(p_eff) + WaveW'(1);
    phase_d = (p_nxt >= wl_eff) ? '0 : p_nxt[PhaseW-1:0];
  end

  // Table position u = round(phase * 2 * depth / wavelength), one quotient
  // bit per step: u = (4 * depth * phase + wl) div (2 * wl).
  always_comb begin
    num     = (NumW'(p_eff) << QuotW) + NumW'(wl_eff);
    divisor = DivW'({wl_eff, 1'b0});
    trial   = {rem_q, numlo_q[QuotW-1]};
    q_bit   = (trial >= {1'b0, divisor});
    rem_nxt = q_bit ? DivW'(trial - {1'b0, divisor}) : DivW'(trial);
  end

  // Ease factor f = (1 - c) / 2, with c read from the quarter-wave table and
  // mirrored and negated for the second quarter.
  always_comb begin
    tab_idx = (numlo_q < QuotW'(CosDepth)) ? numlo_q[TabIdxW-1:0]
                                           : TabIdxW'('0 - numlo_q[TabIdxW-1:0]);
    tab_val = CosTable[tab_idx];
    if (numlo_q < QuotW'(CosDepth)) begin
      f_sum = (FracBits+2)'(OneQf) - (FracBits+2)'(tab_val);
    end else if (numlo_q == QuotW'(CosDepth)) begin
      f_sum = (FracBits+2)'(OneQf);
    end else begin
      f_sum = (FracBits+2)'(OneQf) + (FracBits+2)'(tab_val);
    end
    f_d = FracW'(f_sum >> 1);
  end

  // Draw r = top bits of the generator minus one half; its magnitude + 2
  // feeds the divide-by-five multiply that rounds 0.2 * r.
  always_comb begin
    draw_neg = !lcg_q[SampleW-1];
    draw_r   = {~lcg_q[SampleW-1], lcg_q[SampleW-2:SampleW-FracBits]};
    if (draw_neg) begin
      mag = MagW'(-(MagW'(draw_r)));
    end else begin
      mag = MagW'(draw_r);
    end
    mag_p2 = mag + MagW'(2);
  end

  // Shared multiplier operands.
  always_comb begin
    case (uw.mul_a)
      MA_LCG:  mul_a = {1'b0, lcg_q};
      MA_DIFF: mul_a = {to_q[SampleW-1], to_q} - {from_q[SampleW-1], from_q};
      MA_MAG:  mul_a = MulAW'(mag_p2);
      MA_Y:    mul_a = {y_q[SampleW-1], y_q};
      default: mul_a = '0;
    endcase
    case (uw.mul_b)
      MB_LCG:  mul_b = MulBW'(LcgMul);
      MB_FIVE: mul_b = DivFiveMul;
      MB_FRAC: mul_b = MulBW'(f_q);
      MB_AMP:  mul_b = {{(MulBW-AmpW){amp_q[AmpW-1]}}, amp_q};
      default: mul_b = '0;
    endcase
  end

  // Results taken from the registered product.
  always_comb begin
    lcg_nxt  = prod_q[SampleW-1:0] + LcgAdd;

    step_mag = prod_q[DivFiveShift +: FracBits];
    step     = draw_neg ? -SumW'(step_mag) : SumW'(step_mag);
    knot_sum = {{2{to_q[SampleW-1]}}, to_q} + step;
    knot_nxt = sat_sample(ProdW'(knot_sum));

    bl_rnd   = prod_q + (ProdW'(1) << (FracBits - 1));
    bl_sh    = bl_rnd >>> FracBits;
    y_blend  = from_q + bl_sh[SampleW-1:0];

    g_rnd    = prod_q + (ProdW'(1) << (AmpFracBits - 1));
    g_sh     = g_rnd >>> AmpFracBits;
    gain     = sat_sample(g_sh);
  end

  // Control state, generator, configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UpcP0;
      lcg_q       <= '0;
      amp_q       <= AmpReset;
      wave_q      <= WaveReset;
      phase_q     <= '0;
      cnt_q       <= '0;
      knot_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;

      if (uw.op == OP_LCG) begin
        lcg_q <= lcg_nxt;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEED:       lcg_q  <= cfg_data_i[SampleW-1:0];
          CFG_AMPLITUDE:  amp_q  <= cfg_data_i[AmpW-1:0];
          CFG_WAVELENGTH: wave_q <= cfg_data_i[WaveW-1:0];
          default:        ;
        endcase
      end

      if (uw.op == OP_DISPATCH) begin
        cnt_q  <= CntW'(QuotW - 1);
        knot_q <= p_zero;
      end else if (uw.op == OP_DIV_STEP) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      if (uw.op == OP_TO_DRAW) begin
        phase_q <= '0;
      end else if (out_load) begin
        phase_q <= phase_d;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (uw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (uw.op)
      OP_DISPATCH: begin
        rem_q   <= DivW'(num[NumW-1:QuotW]);
        numlo_q <= num[QuotW-1:0];
      end
      OP_DIV_STEP: begin
        rem_q   <= rem_nxt;
        numlo_q <= {numlo_q[QuotW-2:0], q_bit};
      end
      OP_FRAC: begin
        f_q <= f_d;
      end
      OP_BLEND: begin
        y_q <= y_blend;
      end
      OP_KNOT: begin
        from_q <= to_q;
        to_q   <= knot_nxt;
        y_q    <= to_q;
      end
      OP_FROM_DRAW: begin
        from_q <= SampleW'(draw_r);
      end
      OP_TO_DRAW: begin
        to_q <= SampleW'(draw_r);
      end
      default: ;
    endcase
    if (out_load) begin
      sample_q   <= gain;
      out_knot_q <= knot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign at_knot_o   = out_knot_q;

endmodule

// ----- hdl/lvn_checker.sv -----
// Port-level checker for the value noise core, bound to the top level.
`include "lcg_value_noise_1d_core_assert.svh"

module lvn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               tick_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [lvn_pkg::SampleW-1:0] sample_o,
  input logic                               at_knot_o,
  input logic                               cfg_we_i,
  input logic        [lvn_pkg::CfgIdxW-1:0] cfg_idx_i
);
  import lvn_pkg::*;

  logic out_wait;
  logic seed_wr;

  assign out_wait = out_valid_o && out_stall_i;
  assign seed_wr  = cfg_we_i && (cfg_idx_i == CFG_SEED);

  // A stalled result holds.
  `LVN_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable({sample_o, at_knot_o}), "held result changed")

  // A new result only appears at the end of a busy sequence.
  `LVN_ASSERT_NOW(a_out_from_work, $rose(out_valid_o), $past(in_stall_o), "result without work")

  // An accepted tick occupies the sequencer.
  `LVN_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && tick_i, in_stall_o, "tick did not start work")

  // A seed write starts priming, which blocks input.
  `LVN_ASSERT_NEXT(a_seed_prime, seed_wr, in_stall_o, "seed write did not prime")

endmodule

bind lcg_value_noise_1d_core lvn_checker u_lvn_checker (.*);

// ----- verif/lcg_value_noise_1d_core_tb.sv -----
// Self-checking testbench for the 1-D value noise core: predicted samples vs. DUT output.
`timescale 1ns / 1ps

module lcg_value_noise_1d_core_tb;

  // Timing of the bench
  localparam int HalfPeriod  = 2;
  localparam int ResetCycles = 9;
  localparam int DrainCycles = 24;         // covers the longest item, leave margin
  localparam int TailCycles  = 40;
  localparam int TimeoutNs   = 2_000_000;
  localparam int MaxReports  = 10;

  // Stimulus sizing
  localparam int NumBlocks     = 13;
  localparam int TicksPerBlock = 90;

  // Arithmetic of the noise source
  localparam bit [31:0]       LcgMult    = 32'd1664525;
  localparam bit [31:0]       LcgIncr    = 32'd1;
  localparam int unsigned     CosEntries = 256;
  localparam int unsigned     MaxWaveLen = 1024;
  localparam int              FracShift  = 16;
  localparam int              GainShift  = 8;
  localparam longint          OneQ16     = 64'sd65536;
  localparam longint          HalfQ16    = 64'sd32768;
  localparam longint unsigned PiQ30      = 64'd3373259426;

  // Register index that maps to no register
  localparam logic [lvn_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef enum int {
    IDLE_NONE = 0,
    IDLE_SEND = 1,
    IDLE_RECV = 2,
    IDLE_BOTH = 3
  } idle_mode_e;

  typedef struct {
    logic signed [31:0] sample;
    logic               knot;
  } noise_result_t;

  // Predicts every sample from accepted ticks and register writes, and
  // holds the samples still owed by the DUT.
  class noise_sample_board;
    bit [31:0]     seed_word;
    bit [31:0]     lcg_word;
    longint        gain;
    bit [10:0]     wave_len;
    bit [9:0]      step_phase;
    longint        knot_start;
    longint        knot_target;
    longint        cos_quarter[CosEntries];
    noise_result_t pending_samples[$];
    int unsigned   errors;

    function new();
      errors    = 0;
      seed_word = 32'd0;
      gain      = 256;
      wave_len  = 11'd10;
      build_cosine();
      prime_knots();
    endfunction

    // Quarter-wave cosine in Q1.16 from a Q2.30 Taylor series up to x^16.
    function void build_cosine();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      longint          v;
      for (int i = 0; i < CosEntries; i++) begin
        x   = (PiQ30 * longint'(i)) / (2 * CosEntries);
        x2  = (x * x) >> 30;
        mag = 64'd1 << 30;
        sum = longint'(mag);
        for (int k = 1; k <= 8; k++) begin
          mag = ((mag * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            sum = sum - longint'(mag);
          end else begin
            sum = sum + longint'(mag);
          end
        end
        v = round_half_up(sum, 30 - FracShift);
        if (v < 0) v = 0;
        if (v > OneQ16) v = OneQ16;
        cos_quarter[i] = v;
      end
    endfunction

    function longint round_half_up(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Advance the generator; top 16 bits minus one half.
    function longint draw_offset();
      lcg_word = lcg_word * LcgMult + LcgIncr;
      return longint'(lcg_word[31:16]) - HalfQ16;
    endfunction

    function void prime_knots();
      lcg_word    = seed_word;
      knot_start  = draw_offset();
      knot_target = draw_offset();
      step_phase  = '0;
    endfunction

    function noise_result_t next_sample();
      noise_result_t res;
      int unsigned   wl;
      int unsigned   p;
      int unsigned   u;
      longint        r;
      longint        mag;
      longint        d;
      longint        c;
      longint        f;
      longint        y;
      if (wave_len == 0) begin
        wl = 1;
      end else if (wave_len > MaxWaveLen) begin
        wl = MaxWaveLen;
      end else begin
        wl = wave_len;
      end
      p = (step_phase < wl) ? step_phase : 0;
      if (p == 0) begin
        // knot: the target steps by r/5, ties away from zero
        r   = draw_offset();
        mag = (r < 0) ? -r : r;
        d   = (2 * mag + 5) / 10;
        if (r < 0) d = -d;
        knot_start  = knot_target;
        knot_target = clamp_word(knot_target + d);
        y           = knot_start;
        res.knot    = 1'b1;
      end else begin
        u = (4 * CosEntries * p + wl) / (2 * wl);
        if (u < CosEntries) begin
          c = cos_quarter[u];
        end else if (u == CosEntries) begin
          c = 0;
        end else begin
          c = -cos_quarter[2 * CosEntries - u];
        end
        f = (OneQ16 - c) >>> 1;
        y = knot_start + round_half_up((knot_target - knot_start) * f, FracShift);
        res.knot = 1'b0;
      end
      step_phase = (p + 1 >= wl) ? 10'd0 : 10'(p + 1);
      res.sample = 32'(clamp_word(round_half_up(y * gain, GainShift)));
      return res;
    endfunction

    function void note_item(logic tick_val);
      if (tick_val) pending_samples.push_back(next_sample());
    endfunction

    function void set_reg(logic [lvn_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        lvn_pkg::CFG_SEED: begin
          seed_word = data;
          prime_knots();
        end
        lvn_pkg::CFG_AMPLITUDE: begin
          gain = longint'($signed(data[15:0]));
        end
        lvn_pkg::CFG_WAVELENGTH: begin
          wave_len = data[10:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sample(logic signed [31:0] s, logic k);
      noise_result_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected sample %0d at_knot %0b", $realtime, s, k);
        end
        return;
      end
      want = pending_samples.pop_front();
      if (s !== want.sample || k !== want.knot) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: sample mismatch: expected %0d at_knot %0b, got %0d at_knot %0b",
                   $realtime, want.sample, want.knot, s, k);
        end
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                tick;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [lvn_pkg::SampleW-1:0]  sample;
  logic                                at_knot;
  logic                                cfg_we;
  logic        [lvn_pkg::CfgIdxW-1:0]  cfg_idx;
  logic        [lvn_pkg::CfgDataW-1:0] cfg_data;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  noise_sample_board board;

  lcg_value_noise_1d_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .tick_i      (tick),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_o    (sample),
    .at_knot_o   (at_knot),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #(HalfPeriod) clk = 1'b1;
    #(HalfPeriod) clk = 1'b0;
  end

  // Receiver: stall at random with the current pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watch all three ports at the clock edge. Outputs are read before the
  // edge updates them, so check results first, then log new items and writes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_sample(sample, at_knot);
      if (in_valid && !in_stall) board.note_item(tick);
      if (cfg_we) board.set_reg(cfg_idx, cfg_data);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 16 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 16 : 0;
  endtask

  // Offer one item, with random idle cycles ahead of it; return once taken.
  task automatic send_item(input logic tick_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= tick_val;
    do @(posedge clk); while (in_stall);
  endtask

  // Write one register with the core idle: drop valid, drain every owed
  // sample, then wait out any knot priming still running.
  task automatic write_reg(input logic [lvn_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] amp_val;
    logic [10:0] wl_val;
    logic [31:0] seed_val;
    logic        tick_val;
    int unsigned sent;

    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    tick           = 1'b0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, a knot, an ignored tick, then blends
    set_idling(IDLE_NONE);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b1);

    // Shrink the wavelength below the current phase: next tick lands on a knot
    write_reg(lvn_pkg::CFG_WAVELENGTH, 32'd3);
    send_item(1'b1);
    send_item(1'b1);

    // Zero wavelength acts as one, full positive gain
    write_reg(lvn_pkg::CFG_AMPLITUDE, 32'h0000_7FFF);
    write_reg(lvn_pkg::CFG_WAVELENGTH, 32'd0);
    repeat (3) send_item(1'b1);

    // Wavelength above the limit, most negative gain, all-ones seed
    write_reg(lvn_pkg::CFG_AMPLITUDE, 32'h0000_8000);
    write_reg(lvn_pkg::CFG_WAVELENGTH, 32'h0000_07FF);
    write_reg(lvn_pkg::CFG_SEED, 32'hFFFF_FFFF);
    repeat (3) send_item(1'b1);

    // Largest legal wavelength, zero gain, zero seed
    write_reg(lvn_pkg::CFG_AMPLITUDE, 32'd0);
    write_reg(lvn_pkg::CFG_WAVELENGTH, 32'd1024);
    write_reg(lvn_pkg::CFG_SEED, 32'd0);
    repeat (2) send_item(1'b1);

    // Unused index, then writes whose upper data bits must be ignored
    write_reg(CfgIdxSpare, 32'hDEAD_BEEF);
    write_reg(lvn_pkg::CFG_AMPLITUDE, 32'hA5A5_0100);
    write_reg(lvn_pkg::CFG_WAVELENGTH, 32'hFFFF_F802);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);

    // Random: blocks of ticks, each under fresh settings and idling pressure
    for (int blk = 0; blk < NumBlocks; blk++) begin
      case ($urandom_range(4))
        0:       amp_val = 16'h7FFF;
        1:       amp_val = 16'h8000;
        2:       amp_val = 16'($urandom);
        default: amp_val = 16'($urandom_range(1023)) - 16'd512;
      endcase
      case ($urandom_range(9))
        0:       wl_val = 11'd0;
        1:       wl_val = 11'($urandom_range(2047));
        2:       wl_val = 11'd1024;
        default: wl_val = 11'($urandom_range(12, 1));
      endcase
      case ($urandom_range(7))
        0:       seed_val = 32'h0000_0000;
        1:       seed_val = 32'hFFFF_FFFF;
        default: seed_val = $urandom;
      endcase
      if ($urandom_range(3) != 0) begin
        write_reg(lvn_pkg::CFG_AMPLITUDE, {16'($urandom), amp_val});
      end
      write_reg(lvn_pkg::CFG_WAVELENGTH, {21'($urandom), wl_val});
      // seed last: its write keeps the core busy priming the knots
      if ($urandom_range(3) != 0) begin
        write_reg(lvn_pkg::CFG_SEED, seed_val);
      end

      set_idling(idle_mode_e'(blk % 4));
      sent = 0;
      while (sent < TicksPerBlock) begin
        tick_val = ($urandom_range(9) != 0);
        send_item(tick_val);
        if (tick_val) sent++;
        // hold the sender once mid-stream until every owed sample is out
        if (blk == 5 && sent == TicksPerBlock / 2 && tick_val) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (board.pending_samples.size() != 0);
        end
      end
    end

    in_valid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a lost sample or a hung handshake ends the run here.
  initial begin
    #(TimeoutNs);
    $display("== FAIL ==");
    $finish;
  end

endmodule
